// ===== rtl/rms_pkg.sv =====
package rms_pkg;

	localparam int ACC_W = 40;
	localparam int K_W   = 13;
	localparam int M_W   = 12;
	localparam int BUF_W = 14;
	localparam int IDX_W = 13;
	localparam int COL_W = 14;
	localparam int ADDR_W = 4;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_WEIGHT = 2'd2;

	localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
	localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
	localparam logic [1:0] REG_BUFFER_SIZE  = 2'd2;

	localparam logic signed [ACC_W-1:0] ACC_I32_MAX = 40'sd2147483647;
	localparam logic signed [ACC_W-1:0] ACC_I32_MIN = -40'sd2147483648;

	typedef struct packed {
		logic [K_W-1:0]   input_count;
		logic [M_W-1:0]   output_count;
		logic [BUF_W-1:0] buffer_size;
	} cfg_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [7:0]       value;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] col;
	} rd_req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic                    changed;
	} clamp_t;

	typedef enum logic {
		ST_IDLE,
		ST_MAC
	} state_t;

	function automatic clamp_t clamp_i32(input logic signed [ACC_W-1:0] a);
		clamp_t r;
		r.value   = a;
		r.changed = 1'b0;
		if (a > ACC_I32_MAX) begin
			r.value   = ACC_I32_MAX;
			r.changed = 1'b1;
		end else if (a < ACC_I32_MIN) begin
			r.value   = ACC_I32_MIN;
			r.changed = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/rms_if.sv =====
interface rms_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [12:0]        element_index;
	logic signed [7:0]  element_value;
	logic signed [31:0] bias_value;
	logic signed [15:0] weight_value;

	modport source (
		output valid, operation, element_index, element_value, bias_value, weight_value,
		input  ready
	);
	modport sink (
		input  valid, operation, element_index, element_value, bias_value, weight_value,
		output ready
	);
endinterface

interface rms_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] row_value;
	logic               saturated;

	modport source (
		output valid, row_value, saturated,
		input  ready
	);
	modport sink (
		input  valid, row_value, saturated,
		output ready
	);
endinterface

// ===== rtl/rms_cfg.sv =====
module rms_cfg
	import rms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_count  <= K_W'(16);
			cfg_q.output_count <= M_W'(16);
			cfg_q.buffer_size  <= BUF_W'(16);
		end else if (wr_en) begin
			case (reg_idx)
				REG_INPUT_COUNT:  cfg_q.input_count  <= pwdata[K_W-1:0];
				REG_OUTPUT_COUNT: cfg_q.output_count <= pwdata[M_W-1:0];
				REG_BUFFER_SIZE:  cfg_q.buffer_size  <= pwdata[BUF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INPUT_COUNT:  prdata = 32'(cfg_q.input_count);
			REG_OUTPUT_COUNT: prdata = 32'(cfg_q.output_count);
			REG_BUFFER_SIZE:  prdata = 32'(cfg_q.buffer_size);
			default:          prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/rms_store.sv =====
module rms_store
	import rms_pkg::*;
#(
	parameter int MAX_INPUTS  = 4096,
	parameter int MAX_OUTPUTS = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  wr_req_t          wr,
	input  rd_req_t          rd,
	output logic signed [7:0] rd_data
);

	localparam int IA_W = $clog2(MAX_INPUTS);
	localparam int FA_W = $clog2(MAX_OUTPUTS);

	logic [7:0] in_mem [MAX_INPUTS];
	logic [7:0] fb_mem [MAX_OUTPUTS];

	logic [IDX_W-1:0] wr_fb_idx;
	logic             wr_is_in;
	logic             wr_in;
	logic             wr_fb;
	logic [31:0]      wr_in_ext;
	logic [31:0]      wr_fb_ext;

	logic [COL_W-1:0] rd_fb_idx;
	logic             rd_is_in;
	logic [31:0]      rd_in_ext;
	logic [31:0]      rd_fb_ext;
	logic             rd_hit;

	logic [7:0] in_rd_q;
	logic [7:0] fb_rd_q;
	logic       sel_fb_q;
	logic       hit_q;

	// a load index below K goes to the input store, the rest to feedback
	always_comb begin
		wr_is_in  = wr.idx < cfg.input_count;
		wr_fb_idx = wr.idx - cfg.input_count;
		wr_in_ext = 32'(wr.idx);
		wr_fb_ext = 32'(wr_fb_idx);
		wr_in     = wr.en && wr_is_in && (wr_in_ext < 32'(MAX_INPUTS));
		wr_fb     = wr.en && !wr_is_in && (wr_fb_ext < 32'(MAX_OUTPUTS));

		rd_is_in  = rd.col < COL_W'(cfg.input_count);
		rd_fb_idx = rd.col - COL_W'(cfg.input_count);
		rd_in_ext = 32'(rd.col);
		rd_fb_ext = 32'(rd_fb_idx);
		rd_hit    = rd_is_in ? (rd_in_ext < 32'(MAX_INPUTS))
		                     : (rd_fb_ext < 32'(MAX_OUTPUTS));
	end

	always_ff @(posedge clk) begin
		if (wr_in) begin
			in_mem[wr_in_ext[IA_W-1:0]] <= wr.value;
		end
		if (wr_fb) begin
			fb_mem[wr_fb_ext[FA_W-1:0]] <= wr.value;
		end
		if (rd.en) begin
			in_rd_q <= in_mem[rd_in_ext[IA_W-1:0]];
			fb_rd_q <= fb_mem[rd_fb_ext[FA_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_fb_q <= 1'b0;
			hit_q    <= 1'b0;
		end else if (rd.en) begin
			sel_fb_q <= !rd_is_in;
			hit_q    <= rd_hit;
		end
	end

	// columns past the store depth read as zero
	assign rd_data = !hit_q ? 8'sd0 : (sel_fb_q ? $signed(fb_rd_q) : $signed(in_rd_q));

endmodule

// ===== rtl/rms_row.sv =====
module rms_row
	import rms_pkg::*;
#(
	parameter int WEIGHT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	rms_item_if.sink          item,
	rms_result_if.source      result,
	output rd_req_t           rd,
	input  logic signed [7:0] rd_data
);

	localparam int PROD_W = 8 + WEIGHT_BITS;

	state_t state_q;
	state_t state_d;

	logic signed [ACC_W-1:0]       acc_q;
	logic [COL_W-1:0]              col_q;
	logic [BUF_W-1:0]              seg_q;
	logic                          active_q;
	logic                          clamped_q;
	logic signed [WEIGHT_BITS-1:0] w_s1;

	logic        out_valid_q;
	logic signed [31:0] row_value_q;
	logic        saturated_q;

	logic                    accept;
	logic                    take_weight;
	logic                    out_free;
	logic [COL_W-1:0]        row_len;
	logic [COL_W-1:0]        done_col;
	logic [BUF_W-1:0]        seg_next;
	logic                    last_col;
	logic                    seg_end;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] sum;
	clamp_t                  clamped;
	logic                    mac_fire;

	assign accept      = item.valid && item.ready;
	assign take_weight = accept && (item.operation == OP_WEIGHT) && active_q;
	assign out_free    = !out_valid_q || result.ready;

	always_comb begin
		row_len  = COL_W'(cfg.input_count) + COL_W'(cfg.output_count);
		done_col = col_q + COL_W'(1);
		seg_next = seg_q + BUF_W'(1);
		last_col = done_col >= row_len;
		seg_end  = (cfg.buffer_size != '0) && (seg_next >= cfg.buffer_size);
		prod     = rd_data * w_s1;
		sum      = acc_q + ACC_W'(prod);
		clamped  = clamp_i32(sum);
		// the last column waits here until the output register is free
		mac_fire = (state_q == ST_MAC) && (!last_col || out_free);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (take_weight) state_d = ST_MAC;
			ST_MAC:  if (mac_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_MAC:  item.ready = 1'b0;
			default: item.ready = 1'b0;
		endcase
		rd.en  = take_weight;
		rd.col = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_weight) begin
			w_s1 <= item.weight_value[WEIGHT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			col_q     <= '0;
			seg_q     <= '0;
			active_q  <= 1'b0;
			clamped_q <= 1'b0;
		end else if (accept && (item.operation == OP_BIAS)) begin
			acc_q     <= ACC_W'(item.bias_value);
			col_q     <= '0;
			seg_q     <= '0;
			active_q  <= 1'b1;
			clamped_q <= 1'b0;
		end else if (mac_fire) begin
			if (last_col) begin
				acc_q     <= '0;
				col_q     <= '0;
				seg_q     <= '0;
				active_q  <= 1'b0;
				clamped_q <= 1'b0;
			end else begin
				col_q <= done_col;
				if (seg_end) begin
					acc_q     <= clamped.value;
					seg_q     <= '0;
					clamped_q <= clamped_q || clamped.changed;
				end else begin
					acc_q <= sum;
					seg_q <= seg_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mac_fire && last_col) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_fire && last_col) begin
			row_value_q <= clamped.value[31:0];
			saturated_q <= clamped_q || clamped.changed;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.row_value = row_value_q;
	assign result.saturated = saturated_q;

endmodule

// ===== rtl/recurrent_matvec_segment_saturate.sv =====
// Recurrent layer row engine. Load items write int8 elements into the input
// store (combined index below K) or the feedback store (index minus K); a bias
// item opens a row and each weight item then multiplies the next column, first
// over the K inputs and then over the M feedback elements. Products add up
// exactly and the sum is clamped to int32 at every segment end (every
// buffer_size columns, and after the last column); the last weight of a row
// puts the row value and a saturated flag into the output register. Load and
// bias items are accepted while idle; a weight first reads its column from the
// registered store and then goes through the multiply-accumulate, during which
// no item is accepted, and the last weight of a row also waits there while the
// previous result still sits in the output register. Registers: input_count
// at 0x0, output_count at 0x4, buffer_size at 0x8.
module recurrent_matvec_segment_saturate
	import rms_pkg::*;
#(
	parameter int MAX_INPUTS  = 4096,
	parameter int MAX_OUTPUTS = 2048,
	parameter int WEIGHT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	rms_item_if.sink          item,
	rms_result_if.source      result
);

	cfg_t              cfg;
	wr_req_t           wr;
	rd_req_t           rd;
	logic signed [7:0] rd_data;

	rms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		wr.en    = item.valid && item.ready && (item.operation == OP_LOAD);
		wr.idx   = item.element_index;
		wr.value = item.element_value;
	end

	rms_store #(
		.MAX_INPUTS  (MAX_INPUTS),
		.MAX_OUTPUTS (MAX_OUTPUTS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	rms_row #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item),
		.result  (result),
		.rd      (rd),
		.rd_data (rd_data)
	);

endmodule

// ===== sim/recurrent_matvec_segment_saturate_test.sv =====
module recurrent_matvec_segment_saturate_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rms_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int STORE_IN = 4096;
	localparam int STORE_FB = 2048;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int REPORT_LIMIT = 10;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;

	typedef struct {
		logic [1:0]         op;
		logic [12:0]        idx;
		logic signed [7:0]  elem;
		logic signed [31:0] bias;
		logic signed [15:0] weight;
	} matvec_item_t;

	typedef struct {
		logic signed [31:0] value;
		logic               sat;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rms_item_if item_bus ();
	rms_result_if row_bus ();

	recurrent_matvec_segment_saturate uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_bus),
		.result  (row_bus)
	);

	always #5 clk = ~clk;

	// row engine state as the block should hold it
	int unsigned in_count = 16;
	int unsigned out_count = 16;
	int unsigned seg_len = 16;
	logic signed [7:0] in_mem [0:STORE_IN-1];
	logic signed [7:0] fb_mem [0:STORE_FB-1];
	longint row_sum;
	int unsigned row_column;
	int unsigned segment_fill;
	bit row_open;
	bit row_clamped;

	row_t expected_rows [$];
	int failures = 0;
	int cycle_count = 0;
	int work_items = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	function automatic void clamp_sum();
		if (row_sum > I32_MAX) begin
			row_sum = I32_MAX;
			row_clamped = 1'b1;
		end else if (row_sum < I32_MIN) begin
			row_sum = I32_MIN;
			row_clamped = 1'b1;
		end
	endfunction

	function automatic bit predict_step(input matvec_item_t it, output row_t r);
		int unsigned idx;
		int unsigned c;
		longint x;
		longint w;
		r.value = '0;
		r.sat = 1'b0;
		idx = 32'(it.idx);
		case (it.op)
			OP_LOAD: begin
				if (idx < in_count) begin
					if (idx < STORE_IN)
						in_mem[idx] = it.elem;
				end else if (idx - in_count < STORE_FB) begin
					fb_mem[idx - in_count] = it.elem;
				end
			end
			OP_BIAS: begin
				row_sum = longint'(it.bias);
				row_column = 0;
				segment_fill = 0;
				row_open = 1'b1;
				row_clamped = 1'b0;
			end
			OP_WEIGHT: if (row_open) begin
				c = row_column;
				x = 0;
				w = longint'(it.weight);
				if (c < in_count) begin
					if (c < STORE_IN)
						x = longint'(in_mem[c]);
				end else if (c - in_count < STORE_FB) begin
					x = longint'(fb_mem[c - in_count]);
				end
				row_sum += x * w;
				row_column = c + 1;
				segment_fill++;
				if (row_column >= in_count + out_count) begin
					clamp_sum();
					r.value = row_sum[31:0];
					r.sat = row_clamped;
					row_open = 1'b0;
					row_column = 0;
					segment_fill = 0;
					row_sum = 0;
					row_clamped = 1'b0;
					return 1'b1;
				end
				if (seg_len != 0 && segment_fill >= seg_len) begin
					clamp_sum();
					segment_fill = 0;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic matvec_item_t random_fields(input logic [1:0] op);
		matvec_item_t it;
		it.op = op;
		it.idx = 13'($urandom);
		it.elem = 8'($urandom);
		it.bias = $urandom;
		it.weight = 16'($urandom);
		return it;
	endfunction

	function automatic logic signed [31:0] pick_bias();
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff - $urandom_range(0, 32'h000f_ffff);
			1: return 32'h8000_0000 + $urandom_range(0, 32'h000f_ffff);
			2: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_load_index();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 8191);
		return $urandom_range(0, in_count + out_count);
	endfunction

	task automatic send_item(input matvec_item_t it);
		row_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_bus.valid = 1'b0;
			@(negedge clk);
		end
		item_bus.operation = it.op;
		item_bus.element_index = it.idx;
		item_bus.element_value = it.elem;
		item_bus.bias_value = it.bias;
		item_bus.weight_value = it.weight;
		item_bus.valid = 1'b1;
		do @(posedge clk); while (!item_bus.ready);
		if (it.op != OP_NONE && !(it.op == OP_WEIGHT && !row_open))
			work_items++;
		if (predict_step(it, r))
			expected_rows.push_back(r);
	endtask

	task automatic send_load(input int unsigned idx, input logic signed [7:0] v);
		matvec_item_t it;
		it = random_fields(OP_LOAD);
		it.idx = idx[12:0];
		it.elem = v;
		send_item(it);
	endtask

	task automatic send_bias(input logic signed [31:0] b);
		matvec_item_t it;
		it = random_fields(OP_BIAS);
		it.bias = b;
		send_item(it);
	endtask

	task automatic send_weight(input logic signed [15:0] w);
		matvec_item_t it;
		it = random_fields(OP_WEIGHT);
		it.weight = w;
		send_item(it);
	endtask

	task automatic send_noise();
		send_item(random_fields(OP_NONE));
	endtask

	// let the block run dry so registers can be written
	task automatic wait_rows_done();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_INPUT_COUNT: in_count = value & 32'h1fff;
			REG_OUTPUT_COUNT: out_count = value & 32'h0fff;
			REG_BUFFER_SIZE: seg_len = value & 32'h3fff;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic configure(input int unsigned k, input int unsigned m, input int unsigned b);
		wait_rows_done();
		write_reg(REG_INPUT_COUNT, k);
		write_reg(REG_OUTPUT_COUNT, m);
		write_reg(REG_BUFFER_SIZE, b);
	endtask

	// every column the next rows read gets written first
	task automatic fill_stores();
		int unsigned n;
		n = (in_count + out_count == 0) ? 1 : in_count + out_count;
		for (int unsigned i = 0; i < n; i++)
			send_load(i, 8'($urandom));
	endtask

	task automatic run_row(input bit noisy);
		int r;
		send_bias(pick_bias());
		while (row_open) begin
			r = noisy ? $urandom_range(0, 99) : 99;
			if (r < 8)
				send_load(pick_load_index(), 8'($urandom));
			else if (r < 10)
				send_noise();
			else if (r < 12)
				send_bias(pick_bias());
			else
				send_weight(pick_weight());
		end
	endtask

	task automatic test_directed_rows();
		configure(2, 2, 3);
		send_load(0, -8'sd128);
		send_load(1, 8'sd127);
		send_load(2, -8'sd1);
		send_load(3, 8'sd127);
		send_load(8191, 8'sd1);
		send_noise();
		send_weight(16'sd5);
		// clamps high at the segment end, then comes back down
		send_bias(32'h7fff_ffff);
		send_weight(16'sh8000);
		send_weight(16'sh7fff);
		send_weight(16'sd1);
		send_weight(16'sh8000);
		// restart mid row after a load that changes a later column
		send_bias(32'h8000_0000);
		send_weight(16'sh7fff);
		send_load(1, -8'sd128);
		send_bias(32'sd0);
		send_weight(16'sh7fff);
		send_weight(16'sh8000);
		send_weight(16'sd0);
		send_weight(16'sd0);
		send_bias(32'h8000_0000);
		send_weight(16'sh7fff);
		send_weight(16'sd0);
		send_weight(16'sd0);
		send_weight(16'sh8000);
	endtask

	task automatic test_degenerate_sizes();
		// empty row with no segment length: first weight ends the row
		configure(0, 0, 0);
		fill_stores();
		repeat (3) run_row(1'b1);
		configure(3, 2, 0);
		fill_stores();
		repeat (4) run_row(1'b1);
		configure(1, 1, 1);
		fill_stores();
		repeat (4) run_row(1'b1);
	endtask

	task automatic test_random_rows();
		int sender_mode [4] = '{0, 71, 0, 23};
		int stall_mode [4] = '{0, 0, 71, 23};
		int unsigned k;
		int unsigned m;
		int unsigned b;
		int start;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = sender_mode[p];
			stall_pct = stall_mode[p];
			for (int s = 0; s < 2; s++) begin
				k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
				m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
				case ($urandom_range(0, 4))
					0: b = 1;
					1: b = k + m;
					default: b = $urandom_range(1, k + m + 2);
				endcase
				configure(k, m, b);
				start = work_items;
				fill_stores();
				while (work_items - start < 50) begin
					if ($urandom_range(0, 9) == 0) begin
						if ($urandom_range(0, 1) == 0)
							send_noise();
						else
							send_weight(pick_weight());
					end
					run_row(1'b1);
				end
			end
		end
	endtask

	initial begin
		row_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			row_bus.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_rows
		row_t e;
		if (arst_n && row_bus.valid && row_bus.ready) begin
			if (expected_rows.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected row: value %0d saturated %0b",
						row_bus.row_value, row_bus.saturated);
			end else begin
				e = expected_rows.pop_front();
				if (row_bus.row_value !== e.value || row_bus.saturated !== e.sat) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("row mismatch: expected %0d sat %0b, got %0d sat %0b",
							e.value, e.sat, row_bus.row_value, row_bus.saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.operation = OP_LOAD;
		item_bus.element_index = '0;
		item_bus.element_value = '0;
		item_bus.bias_value = '0;
		item_bus.weight_value = '0;
		row_sum = 0;
		row_column = 0;
		segment_fill = 0;
		row_open = 1'b0;
		row_clamped = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 23;
		stall_pct = 23;
		test_directed_rows();
		test_degenerate_sizes();
		test_random_rows();

		wait_rows_done();
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_rows.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
